/* rtl/vipc_pkg.sv */
package vipc_pkg;

  typedef enum logic [2:0] {
    OP_RAISE    = 3'd0,
    OP_CANCEL   = 3'd1,
    OP_RETURN   = 3'd2,
    OP_DISPATCH = 3'd3,
    OP_STATUS   = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] level;
    logic [7:0] vector;
    logic       pending;
    logic       cpu_accepts;
  } cmd_t;

  typedef struct packed {
    logic       int_fire;
    logic [7:0] int_vector;
    logic       reti_notify;
    logic [2:0] reti_level;
    logic       request_status;
  } rsp_t;

endpackage

/* rtl/vipc_cmd_if.sv */
interface vipc_cmd_if;
  logic            valid;
  logic            ready;
  vipc_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/vipc_rsp_if.sv */
interface vipc_rsp_if;
  logic            valid;
  logic            ready;
  vipc_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/vipc_first.sv */
// Lowest-index set bit: one-hot mask and its index.
module vipc_first #(
  parameter int N = 8
) (
  input  logic [N-1:0]                 bits,
  output logic [N-1:0]                 onehot,
  output logic                         any,
  output logic [(N>1?$clog2(N):1)-1:0] idx
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  always_comb begin
    logic found;
    found  = 1'b0;
    onehot = '0;
    idx    = '0;
    for (int i = 0; i < N; i++) begin
      if (bits[i] && !found) begin
        onehot[i] = 1'b1;
        idx       = IW'(i);
      end
      found = found | bits[i];
    end
    any = found;
  end
endmodule

/* rtl/vectored_interrupt_priority_chain_core.sv */
// Fixed-priority vectored interrupt chain, level 0 highest.
// cmd (sink) carries one word per operation: raise, cancel, return from
// interrupt, try dispatch or status read, with level, vector, pending and
// cpu_accepts. rsp (source) returns exactly one word per command word:
// dispatch flag and vector, return notification and level, status bit.
// A command word is captured in an input register, evaluated in a single
// pass (two priority encoders over NUM_LEVELS bits) and written to the
// output register; throughput is one word per cycle while rsp is not
// stalled. Request, in-service and vector state change when a word moves
// into the output register, so words see each other in order.
// When rsp is stalled the output register holds, the input register fills,
// and cmd.ready drops; nothing is lost. Reset clears all request and
// in-service bits and empties both registers; vectors are unknown until a
// raise writes them.
module vectored_interrupt_priority_chain_core #(
  parameter int NUM_LEVELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  vipc_cmd_if.sink          cmd,
  vipc_rsp_if.source        rsp
);
  localparam int IW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  vipc_pkg::cmd_t          s1;
  logic                    s1_valid;
  vipc_pkg::rsp_t          out_q;
  logic                    out_valid;

  logic [NUM_LEVELS-1:0]   req;
  logic [NUM_LEVELS-1:0]   ins;
  logic [7:0]              vstore [NUM_LEVELS];

  logic                    advance;
  logic                    process;

  logic [NUM_LEVELS-1:0]   lvl_hit;
  logic                    in_range;
  logic                    raise_wr;
  logic [NUM_LEVELS-1:0]   req_a;
  logic [NUM_LEVELS-1:0]   ins_a;
  logic                    try_disp;
  logic                    notify;
  logic                    status;
  logic [NUM_LEVELS-1:0]   req_next;
  logic [NUM_LEVELS-1:0]   ins_next;
  logic                    fire;
  logic [7:0]              fvec;
  vipc_pkg::rsp_t          rsp_next;

  logic [NUM_LEVELS-1:0]   ins_first;
  logic                    ins_any;
  logic [IW-1:0]           ins_idx;
  logic [NUM_LEVELS-1:0]   d_first;
  logic                    d_any;
  logic [IW-1:0]           d_idx;

  assign advance   = !out_valid || rsp.ready;
  assign process   = s1_valid && advance;
  assign cmd.ready = !s1_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_hit[i] = (int'(s1.level) == i);
    end
  end

  assign in_range = |lvl_hit;
  assign raise_wr = (s1.operation == vipc_pkg::OP_RAISE) && in_range;

  vipc_first #(.N(NUM_LEVELS)) u_ins_first (
    .bits   (ins),
    .onehot (ins_first),
    .any    (ins_any),
    .idx    (ins_idx)
  );

  // state as seen by the dispatch attempt
  always_comb begin
    req_a    = req;
    ins_a    = ins;
    try_disp = 1'b0;
    notify   = 1'b0;
    status   = 1'b0;
    unique case (s1.operation)
      vipc_pkg::OP_RAISE: begin
        if (in_range) begin
          req_a    = req | lvl_hit;
          try_disp = 1'b1;
        end
      end
      vipc_pkg::OP_CANCEL: begin
        req_a = req & ~lvl_hit;
      end
      vipc_pkg::OP_RETURN: begin
        if (ins_any) begin
          ins_a    = ins & ~ins_first;
          notify   = 1'b1;
          try_disp = 1'b1;
        end
      end
      vipc_pkg::OP_DISPATCH: begin
        try_disp = 1'b1;
      end
      vipc_pkg::OP_STATUS: begin
        status = |(req & lvl_hit);
      end
      default: begin
      end
    endcase
  end

  // first level that is either in service (blocks) or requesting (wins)
  vipc_first #(.N(NUM_LEVELS)) u_disp_first (
    .bits   (ins_a | req_a),
    .onehot (d_first),
    .any    (d_any),
    .idx    (d_idx)
  );

  always_comb begin
    fire = try_disp && s1.cpu_accepts && d_any && |(d_first & req_a & ~ins_a);
    // raise writes and dispatches in the same pass: bypass the store
    fvec = (raise_wr && |(lvl_hit & d_first)) ? s1.vector : vstore[d_idx];
    req_next = fire ? (req_a & ~d_first) : req_a;
    ins_next = fire ? (ins_a | d_first) : ins_a;
    if (raise_wr && !s1.pending) begin
      req_next = req_next & ~lvl_hit;
    end
  end

  always_comb begin
    rsp_next.int_fire       = fire;
    rsp_next.int_vector     = fire ? fvec : 8'd0;
    rsp_next.reti_notify    = notify;
    rsp_next.reti_level     = notify ? 3'(ins_idx) : 3'd0;
    rsp_next.request_status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      req       <= '0;
      ins       <= '0;
    end else begin
      if (cmd.ready) begin
        s1_valid <= cmd.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (process) begin
        req <= req_next;
        ins <= ins_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1 <= cmd.data;
    end
    if (process) begin
      out_q <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (process && raise_wr && lvl_hit[i]) begin
        vstore[i] <= s1.vector;
      end
    end
  end
endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLEV = 8;
  localparam int PIPE_CYCLES = 2;
  // op codes with no function in the chain
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst;

  vipc_cmd_if cmd ();
  vipc_rsp_if rsp ();

  vectored_interrupt_priority_chain_core #(
    .NUM_LEVELS(NLEV)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the chain
  logic       req_bit [NLEV];
  logic       svc_bit [NLEV];
  logic [7:0] vec_mem [NLEV];

  vipc_pkg::rsp_t pending_rsp [$];
  vipc_pkg::rsp_t got_rsp;
  vipc_pkg::rsp_t want_rsp;
  int unsigned    words_in;
  int unsigned    words_out;
  int unsigned    errors;
  bit             gaps_on;

  initial begin
    for (int i = 0; i < NLEV; i++) begin
      req_bit[i] = 1'b0;
      svc_bit[i] = 1'b0;
      vec_mem[i] = '0;
    end
    words_in  = 0;
    words_out = 0;
    errors    = 0;
    gaps_on   = 1'b1;
  end

  // Highest requesting level goes into service, unless a level at or above
  // it is already in service.
  function automatic logic take_interrupt(input logic accepts, output logic [7:0] v);
    logic hit;
    logic stop;
    hit  = 1'b0;
    stop = !accepts;
    v    = '0;
    for (int i = 0; i < NLEV; i++) begin
      if (!stop) begin
        if (svc_bit[i]) begin
          stop = 1'b1;
        end else if (req_bit[i]) begin
          svc_bit[i] = 1'b1;
          req_bit[i] = 1'b0;
          v          = vec_mem[i];
          hit        = 1'b1;
          stop       = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic vipc_pkg::rsp_t chain_response(input vipc_pkg::cmd_t w);
    vipc_pkg::rsp_t r;
    logic found;
    r     = '0;
    found = 1'b0;
    case (w.operation)
      vipc_pkg::OP_RAISE: begin
        if (w.level < NLEV) begin
          vec_mem[w.level] = w.vector;
          req_bit[w.level] = 1'b1;
          r.int_fire = take_interrupt(w.cpu_accepts, r.int_vector);
          if (!w.pending) req_bit[w.level] = 1'b0;
        end
      end
      vipc_pkg::OP_CANCEL: begin
        if (w.level < NLEV) req_bit[w.level] = 1'b0;
      end
      vipc_pkg::OP_RETURN: begin
        for (int i = 0; i < NLEV; i++) begin
          if (!found && svc_bit[i]) begin
            svc_bit[i]    = 1'b0;
            found         = 1'b1;
            r.reti_notify = 1'b1;
            r.reti_level  = i[2:0];
          end
        end
        // nothing in service: no dispatch attempt either
        if (found) r.int_fire = take_interrupt(w.cpu_accepts, r.int_vector);
      end
      vipc_pkg::OP_DISPATCH: begin
        r.int_fire = take_interrupt(w.cpu_accepts, r.int_vector);
      end
      vipc_pkg::OP_STATUS: begin
        if (w.level < NLEV) r.request_status = req_bit[w.level];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("[%0t] mismatch on result word %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, words_out, field, got, want);
  endtask

  // monitor: predict on accept, compare on result
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        pending_rsp.push_back(chain_response(cmd.data));
        words_in++;
      end
      if (rsp.valid && rsp.ready) begin
        got_rsp = rsp.data;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (got_rsp.int_fire !== want_rsp.int_fire)
            report_mismatch("int_fire", got_rsp.int_fire, want_rsp.int_fire);
          if (got_rsp.int_vector !== want_rsp.int_vector)
            report_mismatch("int_vector", got_rsp.int_vector, want_rsp.int_vector);
          if (got_rsp.reti_notify !== want_rsp.reti_notify)
            report_mismatch("reti_notify", got_rsp.reti_notify, want_rsp.reti_notify);
          if (got_rsp.reti_level !== want_rsp.reti_level)
            report_mismatch("reti_level", got_rsp.reti_level, want_rsp.reti_level);
          if (got_rsp.request_status !== want_rsp.request_status)
            report_mismatch("request_status", got_rsp.request_status,
                            want_rsp.request_status);
        end
        words_out++;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    rsp.ready <= !gaps_on || ($urandom_range(0, 99) >= 10);
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_word(input vipc_pkg::cmd_t w);
    int unsigned start;
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= w;
    start = words_in;
    do @(negedge clk); while (words_in == start);
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [2:0] lvl,
                             input logic [7:0] v, input logic pend, input logic acc);
    vipc_pkg::cmd_t w;
    w.operation   = op;
    w.level       = lvl;
    w.vector      = v;
    w.pending     = pend;
    w.cpu_accepts = acc;
    send_word(w);
  endtask

  task automatic wait_idle();
    cmd.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES + 2) @(negedge clk);
  endtask

  function automatic vipc_pkg::cmd_t random_word(input int unsigned acc_pct);
    vipc_pkg::cmd_t w;
    int unsigned    r;
    r = $urandom_range(0, 99);
    if (r < 8)       w.operation = vipc_pkg::OP_CANCEL;
    else if (r < 28) w.operation = vipc_pkg::OP_RETURN;
    else if (r < 43) w.operation = vipc_pkg::OP_DISPATCH;
    else if (r < 53) w.operation = vipc_pkg::OP_STATUS;
    else if (r < 57) w.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    else             w.operation = vipc_pkg::OP_RAISE;
    w.level       = 3'($urandom_range(0, NLEV - 1));
    w.vector      = 8'($urandom_range(0, 255));
    w.pending     = ($urandom_range(0, 99) < 70);
    w.cpu_accepts = ($urandom_range(0, 99) < acc_pct);
    return w;
  endfunction

  task automatic test_directed();
    send_fields(vipc_pkg::OP_RAISE,    3'd0, 8'h00, 1'b1, 1'b1);  // immediate dispatch
    send_fields(vipc_pkg::OP_RETURN,   3'd0, 8'h00, 1'b0, 1'b1);
    send_fields(vipc_pkg::OP_RAISE,    3'd7, 8'hFF, 1'b0, 1'b0);  // not taken, dropped
    send_fields(vipc_pkg::OP_STATUS,   3'd7, 8'h00, 1'b0, 1'b0);
    send_fields(vipc_pkg::OP_RAISE,    3'd3, 8'hA5, 1'b1, 1'b0);  // kept
    send_fields(vipc_pkg::OP_STATUS,   3'd3, 8'h00, 1'b0, 1'b0);
    send_fields(vipc_pkg::OP_RAISE,    3'd5, 8'h5A, 1'b1, 1'b0);
    send_fields(vipc_pkg::OP_DISPATCH, 3'd0, 8'h00, 1'b0, 1'b0);  // cpu refuses
    send_fields(vipc_pkg::OP_DISPATCH, 3'd0, 8'h00, 1'b0, 1'b1);  // level 3 goes
    send_fields(vipc_pkg::OP_RAISE,    3'd1, 8'h3C, 1'b1, 1'b1);  // nests above 3
    send_fields(vipc_pkg::OP_DISPATCH, 3'd0, 8'h00, 1'b0, 1'b1);  // blocked by 1
    send_fields(vipc_pkg::OP_RETURN,   3'd0, 8'h00, 1'b0, 1'b1);  // 3 still blocks 5
    send_fields(vipc_pkg::OP_RAISE,    3'd3, 8'hC3, 1'b1, 1'b1);  // same level in service
    send_fields(vipc_pkg::OP_RETURN,   3'd0, 8'h00, 1'b0, 1'b1);  // re-dispatch of 3
    send_fields(vipc_pkg::OP_RETURN,   3'd0, 8'h00, 1'b0, 1'b0);
    send_fields(vipc_pkg::OP_RETURN,   3'd0, 8'h00, 1'b0, 1'b1);  // nothing in service
    send_fields(vipc_pkg::OP_RAISE,    3'd6, 8'h81, 1'b1, 1'b0);
    send_fields(vipc_pkg::OP_CANCEL,   3'd6, 8'h00, 1'b0, 1'b0);
    send_fields(vipc_pkg::OP_STATUS,   3'd6, 8'h00, 1'b0, 1'b0);
    send_fields(vipc_pkg::OP_CANCEL,   3'd2, 8'h00, 1'b0, 1'b0);  // nothing to cancel
    send_fields(vipc_pkg::OP_DISPATCH, 3'd0, 8'h00, 1'b0, 1'b1);  // level 5 goes
    send_fields(vipc_pkg::OP_RAISE,    3'd7, 8'hFF, 1'b0, 1'b1);  // blocked, dropped
    send_fields(vipc_pkg::OP_RETURN,   3'd7, 8'hFF, 1'b1, 1'b1);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_fields(3'(op), 3'd7, 8'hFF, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_mix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(random_word(75));
    wait_idle();
  endtask

  task automatic test_back_to_back(input int unsigned n);
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_word(random_word(75));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // cpu mostly busy: requests pile up across levels before they drain
  task automatic test_request_storm(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(random_word(15));
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    cmd.valid = 1'b0;
    cmd.data  = '0;
    rsp.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_mix(500);
    test_back_to_back(300);
    test_request_storm(300);

    if (errors == 0) begin
      $display("vectored_interrupt_priority_chain_core verification clean");
    end else begin
      $display("vectored_interrupt_priority_chain_core verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("vectored_interrupt_priority_chain_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/vipc_pkg.sv
rtl/vipc_cmd_if.sv
rtl/vipc_rsp_if.sv
rtl/vipc_first.sv
rtl/vectored_interrupt_priority_chain_core.sv
tb/tb.sv
